// File: sv/slcm_pkg.sv
// slcm_pkg: shared types and constants of the stereo level / correlation meter
// used by every module of the meter and by its checker; depends on nothing
package slcm_pkg;

    localparam int SAMPLE_W        = 24;
    localparam int OUT_W           = 24;
    localparam int CORR_W          = 16;
    localparam int FRAC_BITS       = 15;
    localparam int MAX_BLOCK_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int IN_TDATA_W      = 48;
    localparam int OUT_TDATA_W     = 112;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METER_ENABLE = 1'd1;

    localparam logic [CORR_W-1:0] CORR_POS_MAX = 16'h7FFF;
    localparam logic [CORR_W:0]   CORR_NEG_MAG = 17'h08000;
    localparam logic [CORR_W:0]   CORR_WRAP    = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_L,
        ST_SQRT_L,
        ST_DIV_R,
        ST_SQRT_R,
        ST_MUL_P,
        ST_SQRT_P,
        ST_DIV_C,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        OP_DIV_L,
        OP_SQRT_L,
        OP_DIV_R,
        OP_SQRT_R,
        OP_MUL_P,
        OP_SQRT_P,
        OP_DIV_C
    } eng_op_t;

    typedef struct packed {
        logic    accept_ok;
        logic    start;
        eng_op_t op;
        logic    emit;
    } slcm_cmd_t;

    typedef struct packed {
        logic close;
        logic busy;
        logic done;
        logic skip;
        logic out_free;
    } slcm_status_t;

endpackage

// File: sv/stereo_level_correlation_meter.sv
// stereo_level_correlation_meter: top level, configuration registers and
// wiring of controller and datapath; depends on slcm_pkg, slcm_ctrl, slcm_dp
//
//  channel  direction  ports                            contents
//  input    in         s_tvalid s_tready s_tdata s_tlast  one stereo sample pair
//  result   out        m_tvalid m_tready m_tdata          rms, peaks, correlation
//  config   in         cfg_we cfg_index cfg_data          stereo_mode, meter_enable
//
// samples are taken one per cycle while no block is being finished
// a closing transaction starts serial work on the shared one-bit-per-cycle
// divide / root / multiply engine (SUM_W = 59 at default), shorter when the
// correlation is skipped; s_tready stays low during that work and while a
// finished block waits for the result register to be free
// reset (synchronous, active low) restores stereo mode, disables metering,
// clears the block accumulators and empties the result register
module stereo_level_correlation_meter #(
    parameter int MAX_BLOCK   = slcm_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = slcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // left_sample [23:0], right_sample [47:24]
    input  logic [slcm_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // left_rms [23:0], left_peak [47:24], right_rms [71:48],
    // right_peak [95:72], correlation [111:96]
    output logic [slcm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [slcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slcm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import slcm_pkg::*;

    logic stereo_mode_reg;
    logic meter_enable_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stereo_mode_reg  <= 1'b1;
            meter_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STEREO_MODE:  stereo_mode_reg  <= cfg_data[0];
                REG_METER_ENABLE: meter_enable_reg <= cfg_data[0];
                default:          stereo_mode_reg  <= stereo_mode_reg;
            endcase
        end
    end

    slcm_cmd_t    cmd;
    slcm_status_t status;
    logic         in_take;

    // an input transaction completes only while the sequencer is idle
    assign s_tready = cmd.accept_ok;
    assign in_take  = s_tvalid && s_tready;

    slcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    slcm_dp #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_take      (in_take),
        .left_sample  (s_tdata[SAMPLE_W-1:0]),
        .right_sample (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .block_end    (s_tlast),
        .stereo_mode  (stereo_mode_reg),
        .meter_enable (meter_enable_reg),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

endmodule

// File: sv/slcm_ctrl.sv
// slcm_ctrl: sequencer of the end-of-block math (divide, root, multiply)
// depends on slcm_pkg
module slcm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  slcm_pkg::slcm_status_t status,
    output slcm_pkg::slcm_cmd_t    cmd
);
    import slcm_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (status.close) state_next = ST_DIV_L;
            ST_DIV_L:  if (status.done) state_next = ST_SQRT_L;
            ST_SQRT_L: if (status.done) state_next = ST_DIV_R;
            ST_DIV_R:  if (status.done) state_next = ST_SQRT_R;
            ST_SQRT_R: begin
                if (status.done) state_next = status.skip ? ST_EMIT : ST_MUL_P;
            end
            ST_MUL_P:  if (status.done) state_next = ST_SQRT_P;
            ST_SQRT_P: if (status.done) state_next = ST_DIV_C;
            ST_DIV_C:  if (status.done) state_next = ST_EMIT;
            ST_EMIT:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.accept_ok = 1'b0;
        cmd.start     = 1'b0;
        cmd.op        = OP_DIV_L;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd.accept_ok = 1'b1;
            ST_DIV_L:  cmd.op = OP_DIV_L;
            ST_SQRT_L: cmd.op = OP_SQRT_L;
            ST_DIV_R:  cmd.op = OP_DIV_R;
            ST_SQRT_R: cmd.op = OP_SQRT_R;
            ST_MUL_P:  cmd.op = OP_MUL_P;
            ST_SQRT_P: cmd.op = OP_SQRT_P;
            ST_DIV_C:  cmd.op = OP_DIV_C;
            ST_EMIT:   cmd.emit = status.out_free;
            default:   cmd.accept_ok = 1'b0;
        endcase
        if (state_reg != ST_IDLE && state_reg != ST_EMIT) begin
            cmd.start = !status.busy;
        end
    end

endmodule

// File: sv/slcm_dp.sv
// slcm_dp: block accumulators, snapshot, shared serial divide/root/multiply
// engine and result register; depends on slcm_pkg
module slcm_dp #(
    parameter int MAX_BLOCK   = slcm_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = slcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_take,
    input  logic [slcm_pkg::SAMPLE_W-1:0]       left_sample,
    input  logic [slcm_pkg::SAMPLE_W-1:0]       right_sample,
    input  logic                                block_end,
    input  logic                                stereo_mode,
    input  logic                                meter_enable,
    input  slcm_pkg::slcm_cmd_t                  cmd,
    output slcm_pkg::slcm_status_t               status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [slcm_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import slcm_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int SQ_W   = 2 * SB;
    localparam int SUM_W  = 2 * SB - 1 + $clog2(MAX_BLOCK);
    localparam int CS_W   = SUM_W + 1;
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int RT_W   = SUM_W;
    localparam int DVD_W  = SUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DVD_W + 1);

    // sample magnitudes
    logic [SB-1:0] lx, rx, lm, rm, rm_raw;
    logic          lneg, rneg, rneg_raw;
    logic [SQ_W-1:0] lsq, rsq, xprod;

    assign lx       = left_sample[SB-1:0];
    assign rx       = right_sample[SB-1:0];
    assign lneg     = lx[SB-1];
    assign rneg_raw = rx[SB-1];
    assign lm       = lneg ? (~lx + 1'b1) : lx;
    assign rm_raw   = rneg_raw ? (~rx + 1'b1) : rx;
    assign rm       = stereo_mode ? rm_raw : lm;
    assign rneg     = stereo_mode ? rneg_raw : lneg;
    assign lsq      = lm * lm;
    assign rsq      = rm * rm;
    assign xprod    = lm * rm;

    // running block state
    logic [SUM_W-1:0]  lsum_reg, rsum_reg, lsum_next, rsum_next;
    logic signed [CS_W-1:0] cs_reg, cs_next;
    logic [SB-1:0]     lpk_reg, rpk_reg, lpk_next, rpk_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              close;

    assign lsum_next = lsum_reg + {{(SUM_W-SQ_W){1'b0}}, lsq};
    assign rsum_next = rsum_reg + {{(SUM_W-SQ_W){1'b0}}, rsq};
    assign cs_next   = (lneg != rneg) ? cs_reg - $signed({{(CS_W-SQ_W){1'b0}}, xprod})
                                      : cs_reg + $signed({{(CS_W-SQ_W){1'b0}}, xprod});
    assign lpk_next  = (lm > lpk_reg) ? lm : lpk_reg;
    assign rpk_next  = (rm > rpk_reg) ? rm : rpk_reg;
    assign cnt_next  = cnt_reg + 1'b1;
    assign close     = in_take && meter_enable &&
                       (block_end || cnt_next == CNT_W'(MAX_BLOCK));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsum_reg <= '0;
            rsum_reg <= '0;
            cs_reg   <= '0;
            lpk_reg  <= '0;
            rpk_reg  <= '0;
            cnt_reg  <= '0;
        end else if (in_take) begin
            if (!meter_enable || close) begin
                lsum_reg <= '0;
                rsum_reg <= '0;
                cs_reg   <= '0;
                lpk_reg  <= '0;
                rpk_reg  <= '0;
                cnt_reg  <= '0;
            end else begin
                lsum_reg <= lsum_next;
                rsum_reg <= rsum_next;
                cs_reg   <= cs_next;
                lpk_reg  <= lpk_next;
                rpk_reg  <= rpk_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // snapshot of the closed block
    logic [SUM_W-1:0]       sl_reg, sr_reg;
    logic signed [CS_W-1:0] cb_reg;
    logic [SB-1:0]          lp_reg, rp_reg;
    logic [CNT_W-1:0]       n_reg;
    logic                   mode_reg;

    always_ff @(posedge aclk) begin
        if (close) begin
            sl_reg   <= lsum_next;
            sr_reg   <= rsum_next;
            cb_reg   <= cs_next;
            lp_reg   <= lpk_next;
            rp_reg   <= rpk_next;
            n_reg    <= cnt_next;
            mode_reg <= stereo_mode;
        end
    end

    logic [CS_W-1:0]  cmag_w;
    assign cmag_w = cb_reg[CS_W-1] ? CS_W'(-cb_reg) : CS_W'(cb_reg);

    // shared serial engine
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    eng_op_t           op_reg;
    logic [DVD_W-1:0]  dvd_reg;     // dividend shifting out, quotient shifting in
    logic [RT_W-1:0]   dvs_reg;
    logic [RT_W-1:0]   rem_reg;
    logic [2*RT_W-1:0] rad_reg;
    logic [RT_W:0]     srem_reg;
    logic [RT_W-1:0]   root_reg;
    logic [RT_W-1:0]   mpl_reg;
    logic [2*RT_W-1:0] mcd_reg;
    logic [2*RT_W-1:0] acc_reg;
    logic [OUT_W-1:0]  lrms_reg, rrms_reg;

    logic [RT_W:0]   dt;
    logic            dge;
    logic [RT_W+2:0] st, strial;
    logic            sge;
    logic            done;

    assign dt     = {rem_reg, dvd_reg[DVD_W-1]};
    assign dge    = dt >= {1'b0, dvs_reg};
    assign st     = {srem_reg, rad_reg[2*RT_W-1 -: 2]};
    assign strial = {1'b0, root_reg, 2'b01};
    assign sge    = st >= strial;
    assign done   = busy_reg && step_reg == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg <= cmd.op;
            unique case (cmd.op)
                OP_DIV_L, OP_DIV_R, OP_DIV_C: begin
                    step_reg <= STEP_W'(DVD_W);
                    rem_reg  <= '0;
                end
                OP_SQRT_L, OP_SQRT_R, OP_SQRT_P: begin
                    step_reg <= STEP_W'(RT_W);
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                OP_MUL_P: begin
                    step_reg <= STEP_W'(RT_W);
                    acc_reg  <= '0;
                    mpl_reg  <= sl_reg;
                    mcd_reg  <= {{RT_W{1'b0}}, sr_reg};
                end
                default: step_reg <= '0;
            endcase
            unique case (cmd.op)
                OP_DIV_L: begin
                    dvd_reg <= {{FRAC_BITS{1'b0}}, sl_reg};
                    dvs_reg <= {{(RT_W-CNT_W){1'b0}}, n_reg};
                end
                OP_DIV_R: begin
                    dvd_reg <= {{FRAC_BITS{1'b0}}, sr_reg};
                    dvs_reg <= {{(RT_W-CNT_W){1'b0}}, n_reg};
                end
                OP_DIV_C: begin
                    dvd_reg <= {cmag_w[SUM_W-1:0], {FRAC_BITS{1'b0}}};
                    dvs_reg <= root_reg;
                end
                OP_SQRT_L, OP_SQRT_R: rad_reg <= {{RT_W{1'b0}}, dvd_reg[SUM_W-1:0]};
                OP_SQRT_P:            rad_reg <= acc_reg;
                default:              rad_reg <= rad_reg;
            endcase
        end else if (busy_reg && !done) begin
            step_reg <= step_reg - 1'b1;
            unique case (op_reg)
                OP_DIV_L, OP_DIV_R, OP_DIV_C: begin
                    rem_reg <= dge ? RT_W'(dt - {1'b0, dvs_reg}) : dt[RT_W-1:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], dge};
                end
                OP_SQRT_L, OP_SQRT_R, OP_SQRT_P: begin
                    srem_reg <= sge ? (RT_W+1)'(st - strial) : st[RT_W:0];
                    root_reg <= {root_reg[RT_W-2:0], sge};
                    rad_reg  <= {rad_reg[2*RT_W-3:0], 2'b00};
                end
                OP_MUL_P: begin
                    if (mpl_reg[0]) acc_reg <= acc_reg + mcd_reg;
                    mpl_reg <= mpl_reg >> 1;
                    mcd_reg <= mcd_reg << 1;
                end
                default: step_reg <= '0;
            endcase
        end else if (done) begin
            if (op_reg == OP_SQRT_L) lrms_reg <= root_reg[OUT_W-1:0];
            if (op_reg == OP_SQRT_R) rrms_reg <= root_reg[OUT_W-1:0];
        end
    end

    // correlation from the final quotient
    logic              skip;
    logic [CORR_W-1:0] corr;
    logic [CORR_W:0]   qn;

    assign skip = !mode_reg || sl_reg == '0 || sr_reg == '0;

    always_comb begin
        qn = (dvd_reg > DVD_W'(CORR_NEG_MAG)) ? CORR_NEG_MAG : dvd_reg[CORR_W:0];
        if (skip || dvs_reg == '0) begin
            corr = '0;
        end else if (cb_reg[CS_W-1]) begin
            corr = CORR_W'(CORR_WRAP - qn);
        end else if (dvd_reg > DVD_W'(CORR_POS_MAX)) begin
            corr = CORR_POS_MAX;
        end else begin
            corr = dvd_reg[CORR_W-1:0];
        end
    end

    // result register
    logic out_free;
    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata <= {corr,
                        {(OUT_W-SB){1'b0}}, rp_reg,
                        rrms_reg,
                        {(OUT_W-SB){1'b0}}, lp_reg,
                        lrms_reg};
        end
    end

    assign status.close    = close;
    assign status.busy     = busy_reg;
    assign status.done     = done;
    assign status.skip     = skip;
    assign status.out_free = out_free;

endmodule

// File: sv/slcm_checker.sv
// slcm_checker: port-level checks of the meter, bound to the top level
// depends on slcm_pkg and stereo_level_correlation_meter
module slcm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [slcm_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import slcm_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // intake only closes after an input transaction
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("intake closed without a transaction");

    // a new result appears only after the block math ran with intake closed
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while intake was open");

endmodule

bind stereo_level_correlation_meter slcm_checker u_slcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
